// ===== design/swtm_pkg.sv =====
`timescale 1ns / 1ps
package swtm_pkg;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int WLEN_BITS       = 7;
    localparam int TRIM_BITS       = 5;
    localparam int AVG_BITS        = 16;
    localparam logic CFG_WLEN = 1'b0;
    localparam logic CFG_TRIM = 1'b1;

    // shift command broadcast to every cell
    typedef struct packed {
        logic do_remove;
        logic do_insert;
        logic do_sum;
    } t_cell_ctl;
endpackage

// ===== design/swtm_cell.sv =====
`timescale 1ns / 1ps
// One sorted slot. Removal closes the gap by pulling from the right neighbor;
// insertion opens a gap by pulling from the left neighbor. In sum mode the
// cells form a shift line toward cell 0 so the sum unit sees one value a cycle.
module swtm_cell
    import swtm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_key,
    input  logic                   i_used,
    input  logic [SAMPLE_BITS-1:0] i_left_val,
    input  logic                   i_left_gt,
    input  logic [SAMPLE_BITS-1:0] i_right_val,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic                   o_gt
);
    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;
    logic                   w_hit;

    assign o_val = r_val;
    assign o_gt  = i_used && (r_val > i_key);
    // window is sorted: every slot from the first copy of the key on holds a
    // value no less than the key; free slots just follow along
    assign w_hit = !i_used || (r_val >= i_key);

    always_comb begin
        n_val = r_val;
        if (i_ctl.do_remove) begin
            if (w_hit) n_val = i_right_val;
        end else if (i_ctl.do_insert) begin
            if (o_gt || !i_used) begin
                if (i_left_gt) n_val = i_left_val;
                else if (o_gt || !i_used) n_val = i_key;
            end
        end else if (i_ctl.do_sum) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end
endmodule

// ===== design/swtm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module swtm_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic [DEN_BITS:0]   w_try;

    assign w_try  = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
    assign o_quot = r_quot;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(NUM_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            else             r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            if (w_try >= {1'b0, r_den}) begin
                r_rem  <= w_try - {1'b0, r_den};
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_try;
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== design/swtm_ram.sv =====
`timescale 1ns / 1ps
module swtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/sliding_window_trimmed_mean.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_ready   | i_sample
// out     | output    | o_valid / i_ready   | o_trimmed_average, o_window_full
// cfg     | input     | i_cfg_we            | i_cfg_index, i_cfg_data
// One word at a time. After the accepting edge the ring is read, the oldest word is removed
// (full window only) and the new word is inserted. A full window then rotates the whole chain
// past the sum unit, and the serial divider forms the quotient. Reset (sync, active low)
// empties the window; the result register lets the next word enter while a result waits,
// and that word holds in ST_OUT until the result leaves.
module sliding_window_trimmed_mean
    import swtm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [AVG_BITS-1:0]    o_trimmed_average,
    output logic                   o_window_full,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_BITS-1:0]    i_cfg_data
);
    localparam int IDX_BITS = $clog2(WINDOW_MAX);
    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_REM = 3'd2,
                           ST_INS = 3'd3, ST_SUM = 3'd4, ST_DIV = 3'd5,
                           ST_OUT = 3'd6;

    logic [2:0]             r_state;
    logic [WLEN_BITS-1:0]   r_wlen;
    logic [TRIM_BITS-1:0]   r_trim;
    logic [IDX_BITS-1:0]    r_head;
    logic [CNT_BITS-1:0]    r_fill;
    logic [SAMPLE_BITS-1:0] r_key;
    logic [CNT_BITS-1:0]    r_pos;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_ovalid;
    logic [AVG_BITS-1:0]    r_avg;
    logic                   r_full;
    logic [AVG_BITS-1:0]    r_res_avg;
    logic                   r_res_full;
    logic                   w_accept;
    logic                   w_load;

    // effective window and trim
    logic [CNT_BITS-1:0] w_w, w_t, w_den;
    logic [CNT_BITS:0]   w_wraw;
    always_comb begin
        w_wraw = (CNT_BITS+1)'(r_wlen);
        if (w_wraw > (CNT_BITS+1)'(WINDOW_MAX)) w_wraw = (CNT_BITS+1)'(WINDOW_MAX);
        if (w_wraw == '0) w_wraw = (CNT_BITS+1)'(1);
        w_w = CNT_BITS'(w_wraw);
        if ({1'b0, r_trim, 1'b0} >= (TRIM_BITS+2)'(w_w))
            w_t = CNT_BITS'((w_w - 1'b1) >> 1);
        else
            w_t = CNT_BITS'(r_trim);
        w_den = w_w - CNT_BITS'({w_t, 1'b0});
    end

    assign o_ready  = (r_state == ST_IDLE) && !i_cfg_we;
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    // arrival ring: the old word at the head is read while the new one is written
    logic [SAMPLE_BITS-1:0] w_old;
    swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
        .i_clk(i_clk), .i_we(r_state == ST_READ), .i_addr(r_head), .i_wdata(r_key),
        .o_rdata(w_old)
    );

    // cell chain
    t_cell_ctl              w_ctl;
    logic [SAMPLE_BITS-1:0] w_val [WINDOW_MAX];
    logic                   w_gt  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] w_key;
    assign w_ctl.do_remove = (r_state == ST_REM);
    assign w_ctl.do_insert = (r_state == ST_INS);
    assign w_ctl.do_sum    = (r_state == ST_SUM);
    assign w_key = (r_state == ST_REM) ? w_old : r_key;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_lv, w_rv;
        logic w_lg, w_used;
        if (g == 0) begin : g_l
            assign w_lv = '0; assign w_lg = 1'b0;
        end else begin : g_l
            assign w_lv = w_val[g-1]; assign w_lg = w_gt[g-1];
        end
        if (g == WINDOW_MAX-1) begin : g_r
            assign w_rv = w_val[0];
        end else begin : g_r
            assign w_rv = w_val[g+1];
        end
        assign w_used = (CNT_BITS'(g) < r_fill);
        swtm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .i_clk(i_clk), .i_ctl(w_ctl), .i_key(w_key), .i_used(w_used),
            .i_left_val(w_lv), .i_left_gt(w_lg),
            .i_right_val(w_rv), .o_val(w_val[g]), .o_gt(w_gt[g])
        );
    end

    // divider
    logic                w_div_done;
    logic [SUM_BITS-1:0] w_quot;
    logic [SUM_BITS-1:0] n_sum_fin;
    // the chain rotates through all WINDOW_MAX positions so cells return to place;
    // r_pos counts rotation steps, cell 0 holds sorted index r_pos
    assign n_sum_fin = r_sum + ((r_pos >= w_t && r_pos < w_w - w_t) ?
                               SUM_BITS'(w_val[0]) : '0);
    swtm_div #(.NUM_BITS(SUM_BITS), .DEN_BITS(CNT_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == ST_SUM &&
            r_pos == CNT_BITS'(WINDOW_MAX - 1)),
        .i_num(n_sum_fin), .i_den(w_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    assign o_valid = r_ovalid;
    assign o_trimmed_average = r_avg;
    assign o_window_full = r_full;

    logic [IDX_BITS-1:0] w_head_nx;
    assign w_head_nx = (CNT_BITS'(r_head) + 1'b1 >= w_w) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_accept) r_key <= i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wlen   <= WLEN_BITS'(64);
            r_trim   <= TRIM_BITS'(1);
            r_head   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_avg    <= '0;
            r_full   <= 1'b0;
            r_pos    <= '0;
            r_sum    <= '0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_ready);
            if (w_load) begin
                r_avg  <= r_res_avg;
                r_full <= r_res_full;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WLEN) r_wlen <= i_cfg_data;
                else r_trim <= i_cfg_data[TRIM_BITS-1:0];
                r_head <= '0;
                r_fill <= '0;
            end else begin
                unique case (r_state)
                    ST_IDLE: if (w_accept) begin
                        if (r_fill > w_w) begin
                            r_fill <= '0;
                            r_head <= '0;
                        end
                        r_state <= ST_READ;
                    end
                    ST_READ: begin
                        r_head  <= w_head_nx;
                        r_state <= (r_fill == w_w) ? ST_REM : ST_INS;
                    end
                    ST_REM: begin
                        // the oldest word is always held in a full window
                        r_fill  <= r_fill - 1'b1;
                        r_state <= ST_INS;
                    end
                    ST_INS: begin
                        if (r_fill < CNT_BITS'(WINDOW_MAX)) r_fill <= r_fill + 1'b1;
                        r_pos <= '0;
                        r_sum <= '0;
                        if (r_fill + 1'b1 == w_w && r_fill < CNT_BITS'(WINDOW_MAX))
                            r_state <= ST_SUM;
                        else begin
                            r_res_avg  <= '0;
                            r_res_full <= 1'b0;
                            r_state    <= ST_OUT;
                        end
                    end
                    ST_SUM: begin
                        r_sum <= n_sum_fin;
                        r_pos <= r_pos + 1'b1;
                        if (r_pos == CNT_BITS'(WINDOW_MAX - 1)) r_state <= ST_DIV;
                    end
                    ST_DIV: if (w_div_done) begin
                        r_res_avg  <= w_quot[AVG_BITS-1:0];
                        r_res_full <= 1'b1;
                        r_state    <= ST_OUT;
                    end
                    ST_OUT: if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end
endmodule

// ===== design/swtm_checker.sv =====
`timescale 1ns / 1ps
module swtm_checker
    import swtm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic                o_ready,
    input logic                i_valid,
    input logic [AVG_BITS-1:0] o_trimmed_average,
    input logic                o_window_full
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_trimmed_average))
        else $error("result dropped");
    a_notfull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_window_full |-> o_trimmed_average == '0)
        else $error("nonzero average when not full");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken at once");
endmodule

bind sliding_window_trimmed_mean swtm_checker u_swtm_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import swtm_pkg::*;

    typedef struct {
        logic [AVG_BITS-1:0] avg;
        logic                full;
    } t_avg_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [15:0]          i_sample;
    logic                 o_valid;
    logic                 i_ready;
    logic [AVG_BITS-1:0]  o_trimmed_average;
    logic                 o_window_full;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_BITS-1:0]  i_cfg_data;

    sliding_window_trimmed_mean dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_trimmed_average (o_trimmed_average),
        .o_window_full     (o_window_full),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // predictor state
    logic [WLEN_BITS-1:0] win_len_reg;
    logic [TRIM_BITS-1:0] trim_reg;
    logic [15:0]          ring_q [64];
    logic [15:0]          sorted_q [64];
    int                   head_pos;
    int                   held;
    t_avg_word            avg_pending [$];
    int                   fail_count;
    int                   burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_avg_word trimmed_mean_next(logic [15:0] s);
        t_avg_word r;
        int w;
        int t;
        int slot;
        int i;
        int sum;
        logic [15:0] old;
        w = win_len_reg;
        if (w > 64) w = 64;
        if (w == 0) w = 1;
        t = trim_reg;
        if (2 * t >= w) t = (w - 1) / 2;
        slot = head_pos % w;
        if (held == w) begin
            // evict oldest word from the sorted copy
            old = ring_q[slot];
            i = 0;
            while (i < held && sorted_q[i] != old) i++;
            while (i + 1 < held) begin
                sorted_q[i] = sorted_q[i + 1];
                i++;
            end
            held--;
        end
        ring_q[slot] = s;
        head_pos = (slot + 1) % w;
        i = held;
        while (i > 0 && sorted_q[i - 1] > s) begin
            sorted_q[i] = sorted_q[i - 1];
            i--;
        end
        sorted_q[i] = s;
        held++;
        if (held == w) begin
            sum = 0;
            for (i = t; i < w - t; i++) sum += sorted_q[i];
            r.avg  = AVG_BITS'(sum / (w - 2 * t));
            r.full = 1'b1;
        end else begin
            r.avg  = '0;
            r.full = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_avg_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (avg_pending.size() == 0) begin
                report_mismatch("unexpected word", o_trimmed_average, -1);
            end else begin
                e = avg_pending.pop_front();
                if (o_trimmed_average !== e.avg)
                    report_mismatch("trimmed_average", o_trimmed_average, e.avg);
                if (o_window_full !== e.full)
                    report_mismatch("window_full", o_window_full, e.full);
            end
        end
    end

    // receiver stall pattern: calm stretches, random stalls, occasional long stall
    initial begin
        int phase;
        int k;
        i_ready = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            phase = $urandom_range(0, 3);
            if (phase == 0) begin
                for (k = 0; k < 300; k++) begin
                    @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end else if (phase == 3) begin
                @(posedge i_clk);
                i_ready <= 1'b0;
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            end else begin
                for (k = 0; k < 200; k++) begin
                    @(posedge i_clk);
                    i_ready <= ($urandom_range(0, 9) > 2);
                end
            end
        end
    end

    task automatic send_sample(logic [15:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        avg_pending.push_back(trimmed_mean_next(s));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (avg_pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_WLEN) win_len_reg = val;
        else trim_reg = val[TRIM_BITS-1:0];
        head_pos = 0;
        held     = 0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_defaults();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        wait_drained();
    endtask

    task automatic test_small_windows();
        write_reg(CFG_WLEN, 7'd3);
        write_reg(CFG_TRIM, 7'd1);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'hFFFF);
        wait_drained();
        // zero trim averages the whole window
        write_reg(CFG_TRIM, 7'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'h0001);
        wait_drained();
        // trim too large for the window gets clamped
        write_reg(CFG_WLEN, 7'd2);
        write_reg(CFG_TRIM, 7'd31);
        send_sample(16'h1234);
        send_sample(16'hFEDC);
        send_sample(16'h0000);
        wait_drained();
        // zero length acts as one
        write_reg(CFG_WLEN, 7'd0);
        send_sample(16'hFFFF);
        send_sample(16'h8001);
        wait_drained();
        write_reg(CFG_WLEN, 7'd1);
        send_sample(16'h7FFE);
        send_sample(16'h0000);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int p;
        int k;
        int n;
        int mode;
        logic [6:0] wl;
        logic [6:0] tr;
        for (p = 0; p < 16; p++) begin
            case (p)
                0: begin wl = 7'd64;  tr = 7'd1;  end
                1: begin wl = 7'd3;   tr = 7'd1;  end
                2: begin wl = 7'd64;  tr = 7'd31; end
                3: begin wl = 7'd127; tr = 7'd0;  end
                4: begin wl = 7'd4;   tr = 7'd127; end
                5: begin wl = 7'd5;   tr = 7'd0;  end
                default: begin
                    wl = 7'($urandom_range(0, 3) == 0 ? $urandom_range(13, 50)
                                                      : $urandom_range(0, 12));
                    tr = 7'($urandom);
                end
            endcase
            write_reg(CFG_WLEN, wl);
            write_reg(CFG_TRIM, tr);
            if (p < 6) n = (wl >= 30) ? 130 : 55;
            else n = 58;
            mode = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 4) == 0) mode = $urandom_range(0, 3);
                send_sample(rand_sample(mode));
                // sender holds off until the block has emptied once
                if (p == 2 && k == 70) wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_WLEN;
        i_cfg_data  = '0;
        win_len_reg = 7'd64;
        trim_reg    = 5'd1;
        head_pos    = 0;
        held        = 0;
        fail_count  = 0;
        burst_left  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_small_windows();
        test_random_phases();
        if (fail_count == 0 && avg_pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
